// ----- design/phcd_pkg.sv -----
// Package: shared types and constants for the packet header check with dedup.
`default_nettype none
package phcd_pkg;

  // Header is twelve ASCII hex characters
  localparam int unsigned HDR_LEN = 12;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ERROR    = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOT_ME   = 3'd3;
  localparam logic [2:0] ST_NOT_MSTR = 3'd4;
  localparam logic [2:0] ST_OVERSIZE = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_NET_ID     = 2'd0;
  localparam logic [1:0] REG_MY_ADDR    = 2'd1;
  localparam logic [1:0] REG_MASTER     = 2'd2;
  localparam logic [1:0] REG_CHECK_SRC  = 2'd3;

  // Lookup probe that walks down the row of table cells
  typedef struct packed {
    logic       valid;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] mid;
    logic       found;  // some cell already matched or claimed the pair
    logic       dup;    // matched pair carried the same message id
  } probe_t;

endpackage
`default_nettype wire

// ----- design/phcd_cell.sv -----
// One pair-table entry: compares the passing probe, updates or claims the entry.
`default_nettype none
module phcd_cell (
  input  wire              clk,
  input  wire              rst_n,
  input  phcd_pkg::probe_t p_in,
  output phcd_pkg::probe_t p_out
);
  import phcd_pkg::*;

  logic       ent_vld_r, ent_vld_nxt;
  logic [7:0] ent_src_r, ent_src_nxt;
  logic [7:0] ent_dst_r, ent_dst_nxt;
  logic [7:0] ent_id_r,  ent_id_nxt;
  probe_t     p_out_r, p_out_nxt;

  logic live, match, claim;

  // Compare / claim; entries fill from the head, so the first free cell is the next slot
  always_comb begin
    live  = p_in.valid && !p_in.found;
    match = live && ent_vld_r && (ent_src_r == p_in.src) && (ent_dst_r == p_in.dst);
    claim = live && !ent_vld_r;

    ent_vld_nxt = ent_vld_r;
    ent_src_nxt = ent_src_r;
    ent_dst_nxt = ent_dst_r;
    ent_id_nxt  = ent_id_r;
    p_out_nxt   = p_in;

    if (match) begin
      p_out_nxt.found = 1'b1;
      p_out_nxt.dup   = (ent_id_r == p_in.mid);
      ent_id_nxt      = p_in.mid;
    end else if (claim) begin
      p_out_nxt.found = 1'b1;
      ent_vld_nxt     = 1'b1;
      ent_src_nxt     = p_in.src;
      ent_dst_nxt     = p_in.dst;
      ent_id_nxt      = p_in.mid;
    end
  end

  // Entry and probe hand-off registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r     <= 1'b0;
      p_out_r.valid <= 1'b0;
    end else begin
      ent_vld_r     <= ent_vld_nxt;
      p_out_r.valid <= p_out_nxt.valid;
    end
    ent_src_r     <= ent_src_nxt;
    ent_dst_r     <= ent_dst_nxt;
    ent_id_r      <= ent_id_nxt;
    p_out_r.src   <= p_out_nxt.src;
    p_out_r.dst   <= p_out_nxt.dst;
    p_out_r.mid   <= p_out_nxt.mid;
    p_out_r.found <= p_out_nxt.found;
    p_out_r.dup   <= p_out_nxt.dup;
  end

  assign p_out = p_out_r;

endmodule
`default_nettype wire

// ----- design/packet_header_check_dedup.sv -----
// Top level: header parse, payload forwarding, verdict and pair-table lookup chain.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | rx_byte, end_of_packet
//   out_    | output    | out_valid/out_ready| kind, byte, status, addrs, id, full, end
//   cfg_    | input     | cfg_wr_en only     | cfg_index, cfg_wdata
//
// Header and payload bytes are taken while idle; a payload item sits in the
// output register, so the next byte waits only while that register is stalled.
// The final byte is followed by a check state, a search state (when the header
// passes) in which the probe walks the row of table cells, and a verdict state
// that loads the verdict. Reset (rst_n low, synchronous) empties the table at once.
`default_nettype none
module packet_header_check_dedup #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned MAX_PACKET  = 255
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_rx_byte,
  input  wire        in_end_of_packet,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       out_item_kind,
  output logic [7:0] out_payload_byte,
  output logic [2:0] out_status,
  output logic [7:0] out_source_addr,
  output logic [7:0] out_dest_addr,
  output logic [7:0] out_msg_id,
  output logic       out_table_full,
  output logic       out_run_end,
  input  wire        cfg_wr_en,
  input  wire  [1:0] cfg_index,
  input  wire  [7:0] cfg_wdata
);
  import phcd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PACKET + 2);
  localparam logic [CW-1:0] HDR_C = CW'(HDR_LEN);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_VERD   = 2'd3;

  // Hex character decode: bit 4 flags a non-hex byte
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) r = {1'b0, 4'(c - 8'h30)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b0, 4'(c - 8'h37)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b0, 4'(c - 8'h57)};
    return r;
  endfunction

  // Config registers
  logic [7:0] net_id_r, my_addr_r, master_r;
  logic       chk_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_id_r  <= 8'd0;
      my_addr_r <= 8'd0;
      master_r  <= 8'd0;
      chk_src_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NET_ID:    net_id_r  <= cfg_wdata;
        REG_MY_ADDR:   my_addr_r <= cfg_wdata;
        REG_MASTER:    master_r  <= cfg_wdata;
        REG_CHECK_SRC: chk_src_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Control and packet state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [47:0]   hdr_r, hdr_nxt;
  logic          bad_r, bad_nxt;

  // Pending verdict
  logic [2:0] vst_r, vst_nxt;
  logic [7:0] vsrc_r, vsrc_nxt, vdst_r, vdst_nxt, vmid_r, vmid_nxt;
  logic       vfull_r, vfull_nxt;

  // Output register
  logic       ov_r, ov_nxt;
  logic       okind_r, okind_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [7:0] osrc_r, osrc_nxt, odst_r, odst_nxt, omid_r, omid_nxt;
  logic       ofull_r, ofull_nxt;
  logic       oend_r, oend_nxt;

  // Probe chain
  probe_t prb_r, prb_nxt;
  probe_t chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] chain_vld;

  logic        out_free, acc;
  logic [4:0]  hx;
  logic [7:0]  h_net, h_src, h_dst, h_mid;
  logic [15:0] h_len;
  logic [2:0]  fst;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign hx       = hex_dec(in_rx_byte);

  assign h_net = hdr_r[47:40];
  assign h_src = hdr_r[39:32];
  assign h_dst = hdr_r[31:24];
  assign h_mid = hdr_r[23:16];
  assign h_len = hdr_r[15:0];

  // Sequencing: byte intake, header check, chain lookup, verdict
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    bad_nxt   = bad_r;
    vst_nxt   = vst_r;
    vsrc_nxt  = vsrc_r;
    vdst_nxt  = vdst_r;
    vmid_nxt  = vmid_r;
    vfull_nxt = vfull_r;
    prb_nxt   = '0;
    fst       = ST_OK;

    ov_nxt    = ov_r && !out_ready;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    ost_nxt   = ost_r;
    osrc_nxt  = osrc_r;
    odst_nxt  = odst_r;
    omid_nxt  = omid_r;
    ofull_nxt = ofull_r;
    oend_nxt  = oend_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (cnt_r < HDR_C) begin
            hdr_nxt = {hdr_r[43:0], hx[3:0]};
            bad_nxt = bad_r | hx[4];
          end else if (cnt_r < MAX_C) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_PAYLOAD;
            obyte_nxt = in_rx_byte;
            ost_nxt   = ST_OK;
            osrc_nxt  = 8'd0;
            odst_nxt  = 8'd0;
            omid_nxt  = 8'd0;
            ofull_nxt = 1'b0;
            oend_nxt  = 1'b0;
          end
          if (cnt_r <= MAX_C) cnt_nxt = cnt_r + 1'b1;
          if (in_end_of_packet) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        vsrc_nxt  = h_src;
        vdst_nxt  = h_dst;
        vmid_nxt  = h_mid;
        vfull_nxt = 1'b0;
        state_nxt = S_VERD;
        if (cnt_r > MAX_C) begin
          vst_nxt  = ST_OVERSIZE;
          vsrc_nxt = 8'd0;
          vdst_nxt = 8'd0;
          vmid_nxt = 8'd0;
        end else if (cnt_r < HDR_C || bad_r) begin
          vst_nxt  = ST_ERROR;
          vsrc_nxt = 8'd0;
          vdst_nxt = 8'd0;
          vmid_nxt = 8'd0;
        end else if (h_net != net_id_r || h_len != 16'(cnt_r)) begin
          vst_nxt = ST_ERROR;
        end else begin
          prb_nxt.valid = 1'b1;
          prb_nxt.src   = h_src;
          prb_nxt.dst   = h_dst;
          prb_nxt.mid   = h_mid;
          state_nxt     = S_SEARCH;
        end
        cnt_nxt = '0;
        hdr_nxt = '0;
        bad_nxt = 1'b0;
      end
      S_SEARCH: begin
        if (chain[TABLE_DEPTH].valid) begin
          if (chain[TABLE_DEPTH].found && chain[TABLE_DEPTH].dup) fst = ST_DUP;
          else if (vdst_r != my_addr_r) fst = ST_NOT_ME;
          else if (chk_src_r && vsrc_r != master_r) fst = ST_NOT_MSTR;
          vst_nxt   = fst;
          vfull_nxt = !chain[TABLE_DEPTH].found;
          state_nxt = S_VERD;
        end
      end
      S_VERD: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_VERDICT;
          obyte_nxt = 8'd0;
          ost_nxt   = vst_r;
          osrc_nxt  = vsrc_r;
          odst_nxt  = vdst_r;
          omid_nxt  = vmid_r;
          ofull_nxt = vfull_r;
          oend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hdr_r       <= '0;
      bad_r       <= 1'b0;
      ov_r        <= 1'b0;
      prb_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hdr_r       <= hdr_nxt;
      bad_r       <= bad_nxt;
      ov_r        <= ov_nxt;
      prb_r.valid <= prb_nxt.valid;
    end
    prb_r.src   <= prb_nxt.src;
    prb_r.dst   <= prb_nxt.dst;
    prb_r.mid   <= prb_nxt.mid;
    prb_r.found <= prb_nxt.found;
    prb_r.dup   <= prb_nxt.dup;
    vst_r   <= vst_nxt;
    vsrc_r  <= vsrc_nxt;
    vdst_r  <= vdst_nxt;
    vmid_r  <= vmid_nxt;
    vfull_r <= vfull_nxt;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    ost_r   <= ost_nxt;
    osrc_r  <= osrc_nxt;
    odst_r  <= odst_nxt;
    omid_r  <= omid_nxt;
    ofull_r <= ofull_nxt;
    oend_r  <= oend_nxt;
  end

  // Row of table cells; the probe moves one cell per cycle
  assign chain[0] = prb_r;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    phcd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .p_in  (chain[g]),
      .p_out (chain[g+1])
    );
    assign chain_vld[g] = chain[g+1].valid;
  end

  assign out_valid        = ov_r;
  assign out_item_kind    = okind_r;
  assign out_payload_byte = obyte_r;
  assign out_status       = ost_r;
  assign out_source_addr  = osrc_r;
  assign out_dest_addr    = odst_r;
  assign out_msg_id       = omid_r;
  assign out_table_full   = ofull_r;
  assign out_run_end      = oend_r;

  // Checks
  a_chain_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[TABLE_DEPTH].valid |-> state_r == S_SEARCH)
    else $error("lookup result left the chain outside the search state");

  a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({chain_vld, prb_r.valid}) <= 1)
    else $error("more than one probe in the table chain");

  a_verdict_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VERD && out_free) |=>
      (out_valid && out_item_kind == KIND_VERDICT && out_run_end && state_r == S_IDLE))
    else $error("verdict not loaded into the output register");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_kind == KIND_PAYLOAD) |->
      (!out_run_end && out_status == ST_OK && !out_table_full))
    else $error("payload item carries verdict fields");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_CHECK) |-> !in_ready)
    else $error("input taken while a verdict is pending");

endmodule
`default_nettype wire

// ----- test/packet_header_check_dedup_test.sv -----
// Testbench for packet_header_check_dedup: directed and random packets with a self-checking scoreboard.
module packet_header_check_dedup_test;
  import phcd_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned MAX_PACKET  = 255;
  // Longest quiet time the block may need after its last verdict
  localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 14;

  // One result item as seen on the out_ channel
  typedef struct {
    logic       kind;
    logic [7:0] pbyte;
    logic [2:0] status;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] mid;
    logic       full;
    logic       run_end;
  } result_t;

  // Header parser, duplicate table and verdict predictor plus result checker
  class packet_verdict_tracker;
    logic [7:0]  net_id, my_addr, master_addr;
    logic        check_src;
    int unsigned byte_cnt;
    logic [47:0] hdr;
    logic        hdr_bad;
    logic [7:0]  pair_src[TABLE_DEPTH];
    logic [7:0]  pair_dst[TABLE_DEPTH];
    logic [7:0]  pair_mid[TABLE_DEPTH];
    int unsigned pair_cnt;
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      net_id = '0; my_addr = '0; master_addr = '0; check_src = 1'b1;
      byte_cnt = 0; hdr = '0; hdr_bad = 1'b0;
      pair_cnt = 0; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_NET_ID:    net_id = val;
        REG_MY_ADDR:   my_addr = val;
        REG_MASTER:    master_addr = val;
        REG_CHECK_SRC: check_src = val[0];
        default: ;
      endcase
    endfunction

    // ASCII hex digit to its value, -1 if not a digit
    function int hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
    endfunction

    function void note_byte(logic [7:0] b, logic eop);
      int          nib;
      int          hit;
      int unsigned total;
      logic [7:0]  net, src, dst, mid;
      logic [15:0] len;
      logic [2:0]  st;
      logic        full;
      bit          show;
      result_t     r;
      if (byte_cnt < HDR_LEN) begin
        nib = hex_nibble(b);
        if (nib < 0) begin
          hdr_bad = 1'b1;
          nib = 0;
        end
        hdr = {hdr[43:0], 4'(nib)};
      end else if (byte_cnt < MAX_PACKET) begin
        r = '{KIND_PAYLOAD, b, ST_OK, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0};
        pending_results.push_back(r);
      end
      // counter saturates one past the maximum
      if (byte_cnt <= MAX_PACKET) byte_cnt++;
      if (!eop) return;

      total = byte_cnt;
      {net, src, dst, mid, len} = hdr;
      st = ST_OK;
      full = 1'b0;
      show = 1'b1;
      if (total > MAX_PACKET) begin
        st = ST_OVERSIZE;
        show = 1'b0;
      end else if (total < HDR_LEN || hdr_bad) begin
        st = ST_ERROR;
        show = 1'b0;
      end else if (net != net_id || 32'(len) != total) begin
        st = ST_ERROR;
      end else begin
        hit = -1;
        for (int i = 0; i < int'(pair_cnt); i++) begin
          if (hit < 0 && pair_src[i] == src && pair_dst[i] == dst) hit = i;
        end
        if (hit >= 0) begin
          if (pair_mid[hit] == mid) st = ST_DUP;
          else pair_mid[hit] = mid;
        end else if (pair_cnt < TABLE_DEPTH) begin
          pair_src[pair_cnt] = src;
          pair_dst[pair_cnt] = dst;
          pair_mid[pair_cnt] = mid;
          pair_cnt++;
        end else begin
          full = 1'b1;
        end
        if (st == ST_OK) begin
          if (dst != my_addr) st = ST_NOT_ME;
          else if (check_src && src != master_addr) st = ST_NOT_MSTR;
        end
      end
      if (!show) begin
        src = '0; dst = '0; mid = '0;
      end
      r = '{KIND_VERDICT, 8'h0, st, src, dst, mid, full, 1'b1};
      pending_results.push_back(r);
      byte_cnt = 0;
      hdr = '0;
      hdr_bad = 1'b0;
    endfunction

    function void cmp(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: kind %0h byte %0h status %0h",
               got.kind, got.pbyte, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      cmp("item_kind", 8'(want.kind), 8'(got.kind));
      cmp("payload_byte", want.pbyte, got.pbyte);
      cmp("status", 8'(want.status), 8'(got.status));
      cmp("source_addr", want.src, got.src);
      cmp("dest_addr", want.dst, got.dst);
      cmp("msg_id", want.mid, got.mid);
      cmp("table_full", 8'(want.full), 8'(got.full));
      cmp("run_end", 8'(want.run_end), 8'(got.run_end));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = '0;
  logic       in_end_of_packet = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_item_kind;
  logic [7:0] out_payload_byte;
  logic [2:0] out_status;
  logic [7:0] out_source_addr;
  logic [7:0] out_dest_addr;
  logic [7:0] out_msg_id;
  logic       out_table_full;
  logic       out_run_end;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  packet_verdict_tracker sb = new();
  logic [7:0]  pkt[$];
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  packet_header_check_dedup #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_PACKET(MAX_PACKET)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .in_end_of_packet(in_end_of_packet),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item_kind(out_item_kind),
    .out_payload_byte(out_payload_byte),
    .out_status(out_status),
    .out_source_addr(out_source_addr),
    .out_dest_addr(out_dest_addr),
    .out_msg_id(out_msg_id),
    .out_table_full(out_table_full),
    .out_run_end(out_run_end),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: check accepted items, then pick next cycle's ready
  always @(posedge clk) begin : result_side
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_item_kind, out_payload_byte, out_status, out_source_addr,
              out_dest_addr, out_msg_id, out_table_full, out_run_end};
      sb.check_result(got);
    end
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Hex character with random letter case
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // Header (net, src, dst, id, length) followed by random payload
  task automatic make_packet(input logic [7:0] net, input logic [7:0] src,
                             input logic [7:0] dst, input logic [7:0] mid,
                             input int npay, input int len_adj);
    logic [47:0] h;
    h = {net, src, dst, mid, 16'(HDR_LEN + npay + len_adj)};
    pkt.delete();
    for (int i = 11; i >= 0; i--) pkt.push_back(hex_char(h[4*i +: 4]));
    for (int i = 0; i < npay; i++) pkt.push_back(8'($urandom_range(255)));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eop);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_end_of_packet <= eop;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Hold the sender until every expected result is in and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] net, input logic [7:0] me,
                           input logic [7:0] mst, input logic chk);
    logic [7:0] vals[4];
    vals = '{net, me, mst, 8'(chk)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(2'(i), vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed packets over a small address pool, plus broken ones
  task automatic rand_packet();
    int         sel;
    int         npay;
    int         pos;
    logic [7:0] src, dst, mid, nb;
    sel = $urandom_range(99);
    src = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                   : sb.master_addr + 8'($urandom_range(5));
    dst = sb.my_addr + 8'($urandom_range(3));
    mid = 8'($urandom_range(3));
    npay = ($urandom_range(99) < 3) ? $urandom_range(200, 243) : $urandom_range(0, 12);
    if (sel < 70) begin
      make_packet(sb.net_id, src, dst, mid, npay, 0);
    end else if (sel < 78) begin
      make_packet(sb.net_id ^ 8'($urandom_range(1, 255)), src, dst, mid, npay, 0);
    end else if (sel < 85) begin
      make_packet(sb.net_id, src, dst, mid, npay, $urandom_range(1) ? 1 : -1);
    end else if (sel < 90) begin
      // header with one character that is not a hex digit
      make_packet(sb.net_id, src, dst, mid, npay, 0);
      do nb = 8'($urandom_range(255)); while (sb.hex_nibble(nb) >= 0);
      pos = $urandom_range(HDR_LEN - 1);
      pkt[pos] = nb;
    end else if (sel < 95) begin
      make_packet(sb.net_id, src, dst, mid, 0, 0);
      pos = $urandom_range(1, HDR_LEN - 1);
      while (pkt.size() > pos) void'(pkt.pop_back());
    end else if (sel < 97) begin
      make_packet(sb.net_id, src, dst, mid, $urandom_range(244, 260), 0);
    end else begin
      pkt.delete();
      repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom_range(255)));
    end
    send_packet();
  endtask

  task automatic run_phase(input int unsigned snd, input int unsigned rcv,
                           input logic [7:0] net, input logic [7:0] me,
                           input logic [7:0] mst, input logic chk);
    int unsigned start;
    drain();
    configure(net, me, mst, chk);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    start = bytes_sent;
    while (bytes_sent - start < 50) rand_packet();
  endtask

  // Run limit
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [7:0] net, me, mst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets, no idling
    net = 8'hA5; me = 8'h3C; mst = 8'hC3;
    configure(net, me, mst, 1'b1);
    make_packet(net, mst, me, 8'h00, 2, 0);
    pkt[12] = 8'h00;
    pkt[13] = 8'hFF;
    send_packet();                                      // accepted
    make_packet(net, mst, me, 8'h00, 0, 0); send_packet();  // repeat id
    make_packet(net, mst, me, 8'hFF, 1, 0); send_packet();  // new id, same pair
    make_packet(net, mst, me ^ 8'h01, 8'h07, 0, 0); send_packet();  // not for us
    make_packet(net, mst ^ 8'h01, me, 8'h07, 0, 0); send_packet();  // not from master
    make_packet(net ^ 8'hFF, mst, me, 8'h01, 3, 0); send_packet();  // wrong net
    make_packet(net, mst, me, 8'h01, 3, 1); send_packet();  // wrong length
    make_packet(net, mst, me, 8'h01, 0, 0);
    while (pkt.size() > 5) void'(pkt.pop_back());
    send_packet();                                      // short packet
    make_packet(net, mst, me, 8'h01, 0, 0);
    while (pkt.size() > 1) void'(pkt.pop_back());
    send_packet();                                      // single byte
    make_packet(net, mst, me, 8'h01, 2, 0);
    pkt[3] = 8'h47;                                     // 'G' in the header
    send_packet();
    make_packet(net, mst, me, 8'h11, MAX_PACKET - HDR_LEN, 0); send_packet();  // max size
    make_packet(net, mst, me, 8'h12, MAX_PACKET - HDR_LEN + 1, 0); send_packet();  // oversize
    // Fill the pair table and run past it
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      make_packet(net, 8'h80 + 8'(i), me, 8'(i), 0, 0);
      send_packet();
    end

    // Random phases with different settings and idling
    run_phase(0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    run_phase(54, 0, 8'h00, 8'h00, 8'h00, 1'b1);
    run_phase(0, 54, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'b0);
    run_phase(6, 6, 8'h5A, 8'hA5, 8'h5A, 1'b1);

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/phcd_pkg.sv
design/phcd_cell.sv
design/packet_header_check_dedup.sv
test/packet_header_check_dedup_test.sv
